// File: hw/rtl/mfbp_pkg.sv
// Shared constants and types of the MSB-first bit packer.
package mfbp_pkg;

    // Widest field that one item may append; wider requests saturate to it.
    localparam int MAX_FIELD_BITS = 32;

    // Fixed widths of the input fields.
    localparam int CNT_W   = 6;
    localparam int VALUE_W = 32;

    // Pending bits plus one full field.
    localparam int ACC_W     = MAX_FIELD_BITS + 7;
    // Accumulator rounded up to whole bytes, left aligned for the drain.
    localparam int WORD_W    = ((ACC_W + 7) / 8) * 8;
    localparam int MAX_BYTES = WORD_W / 8;
    localparam int NB_W      = $clog2(MAX_BYTES + 1);
    localparam int TOT_W     = $clog2(ACC_W + 1);
    localparam int SH_W      = $clog2(WORD_W + 1);

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One queued job: the bytes to send, MSB first, and how many there are.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [NB_W-1:0]   nbytes;
    } t_entry;

endpackage

// File: hw/rtl/mfbp_front.sv
// Front part: accepts fields, merges them with the pending bits and queues whole bytes.
module mfbp_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mfbp_pkg::CNT_W-1:0]   i_count,
    input  logic [mfbp_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_pad,
    input  logic                        i_full,
    output logic                        o_push,
    output mfbp_pkg::t_entry            o_push_data
);
    import mfbp_pkg::*;

    logic [6:0]       r_pend_bits;
    logic [2:0]       r_pend_cnt;
    logic [6:0]       n_pend_bits;
    logic [2:0]       n_pend_cnt;
    logic             accept;
    logic [TOT_W-1:0] sat_cnt;
    logic [ACC_W-1:0] field_mask;
    logic [ACC_W-1:0] acc;
    logic [TOT_W-1:0] total;
    logic [SH_W-1:0]  shift;
    logic [TOT_W:0]   padded;
    logic [2:0]       rem;
    logic [6:0]       rem_mask;

    function automatic logic [6:0] rem_mask_of_cnt(input logic [2:0] c);
        rem_mask_of_cnt = 7'((8'd1 << c) - 8'd1);
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        if (int'(i_count) > MAX_FIELD_BITS) begin
            sat_cnt = TOT_W'(MAX_FIELD_BITS);
        end else begin
            sat_cnt = TOT_W'(i_count);
        end
        field_mask = (ACC_W'(1) << sat_cnt) - ACC_W'(1);
        acc        = (ACC_W'(r_pend_bits) << sat_cnt) | (ACC_W'(i_value) & field_mask);
        total      = sat_cnt + TOT_W'(r_pend_cnt);
        shift      = SH_W'(WORD_W) - SH_W'(total);
        // A pad rounds the bit total up, so the zero-filled byte comes out too.
        padded     = {1'b0, total} + (i_pad ? (TOT_W+1)'(7) : (TOT_W+1)'(0));
        rem        = total[2:0];
        rem_mask   = 7'((8'd1 << rem) - 8'd1);

        o_push_data.word   = WORD_W'(acc) << shift;
        o_push_data.nbytes = NB_W'(padded >> 3);
        o_push             = accept && (o_push_data.nbytes != '0);

        if (i_pad) begin
            n_pend_bits = '0;
            n_pend_cnt  = '0;
        end else begin
            n_pend_bits = acc[6:0] & rem_mask;
            n_pend_cnt  = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else if (accept) begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

    // A padded field always leaves the stream byte aligned.
    a_pad_aligns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_pad |=> r_pend_cnt == '0)
        else $error("pending bits left after a padded field");

    // Bits above the pending count are always zero.
    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_bits & ~rem_mask_of_cnt(r_pend_cnt)) == '0)
        else $error("stale bits above the pending count");

endmodule

// File: hw/rtl/mfbp_queue.sv
// Small register queue that carries byte jobs from the front to the back.
module mfbp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mfbp_pkg::t_entry i_push_data,
    output logic             o_full,
    output logic             o_valid,
    output mfbp_pkg::t_entry o_data,
    input  logic             i_pop
);
    import mfbp_pkg::*;

    t_entry             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from an empty queue");

endmodule

// File: hw/rtl/mfbp_back.sv
// Back part: drains queued jobs, one byte per cycle unless stalled, into the output register.
module mfbp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  mfbp_pkg::t_entry i_data,
    output logic             o_pop,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [7:0]       o_tdata,
    output logic             o_tlast
);
    import mfbp_pkg::*;

    logic [WORD_W-1:0] r_word;
    logic [NB_W-1:0]   r_left;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              out_free;
    logic              emit;
    logic              load;

    assign out_free = !r_out_valid || i_tready;
    assign emit     = out_free && (r_left != '0);
    // The next job loads while the last byte of the current one goes out.
    assign load     = i_valid && ((r_left == '0) || ((r_left == NB_W'(1)) && out_free));
    assign o_pop    = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_left <= i_data.nbytes;
            end else if (emit) begin
                r_left <= r_left - NB_W'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_data.word;
        end else if (emit) begin
            r_word <= r_word << 8;
        end
        if (emit) begin
            r_out_byte <= r_word[WORD_W-1 -: 8];
            r_out_last <= (r_left == NB_W'(1));
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_byte;
    assign o_tlast  = r_out_last;

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= NB_W'(MAX_BYTES))
        else $error("byte count of the current job out of range");

endmodule

// File: hw/rtl/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer: front, queue and back wired together.
// Path: with the queue empty and the back idle, an accepted item is written into the queue,
// loaded into the back, then its first byte is registered; queued jobs and output stalls delay it.
// Throughput: the front takes one item per cycle while its four-entry queue has room; the back
// sends one byte per cycle unless the output stalls, so an item takes one transfer per byte.
// A field that completes no byte never enters the queue and never occupies the output.
// Reset is synchronous and active low; it empties the queue and leaves the stream byte aligned.
module msb_first_bit_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input transaction: one bit field.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [5:0] bit_count, [37:6] bit_value, [39:38] zero
    input  logic        i_s_tuser,   // [0] pad_to_byte
    // Output transaction: one packed byte.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tlast    // out_last: final byte caused by one input field
);
    import mfbp_pkg::*;

    logic   q_push;
    t_entry q_push_data;
    logic   q_full;
    logic   q_valid;
    t_entry q_data;
    logic   q_pop;

    // The front holds the partial byte and turns each field into a left-aligned
    // job of whole bytes, including the zero-filled byte that a pad closes.
    mfbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_count     (i_s_tdata[CNT_W-1:0]),
        .i_value     (i_s_tdata[CNT_W+VALUE_W-1:CNT_W]),
        .i_pad       (i_s_tuser),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // The queue lets the front keep taking fields while the output is stalled.
    mfbp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (q_pop)
    );

    // The back shifts each job out one byte per unstalled cycle and marks its final byte.
    mfbp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_data   (q_data),
        .o_pop    (q_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

endmodule

// File: tb/mfbp_checker.sv
// Scoreboard for the MSB-first bit packer: predicts the packed byte stream and checks the output.
module mfbp_checker
    import mfbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_stream_byte;

    t_stream_byte expected_bytes[$];
    logic [6:0]   partial_bits;
    logic [2:0]   partial_cnt;
    int           fail_count;

    initial begin
        partial_bits  = '0;
        partial_cnt   = '0;
        fail_count    = 0;
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // Appends one field to the predicted stream and queues every byte it completes.
    function automatic void append_field(logic [CNT_W-1:0] count, logic [VALUE_W-1:0] value,
                                         logic pad);
        logic [7:0]   made [0:MAX_BYTES];
        logic [7:0]   shifted;
        logic         in_bit;
        int           width;
        int           n;
        t_stream_byte entry;
        width = (int'(count) > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(count);
        n = 0;
        for (int pos = width - 1; pos >= 0; pos--) begin
            in_bit  = (pos < VALUE_W) ? value[pos] : 1'b0;
            shifted = {partial_bits, in_bit};
            if (partial_cnt == 3'd7) begin
                made[n]      = shifted;
                n++;
                partial_bits = '0;
                partial_cnt  = '0;
            end else begin
                partial_bits = shifted[6:0];
                partial_cnt  = partial_cnt + 3'd1;
            end
        end
        // A pad flushes the partial byte with zeros in its low bit positions.
        if (pad && partial_cnt != 3'd0) begin
            made[n]      = {1'b0, partial_bits} << (4'd8 - {1'b0, partial_cnt});
            n++;
            partial_bits = '0;
            partial_cnt  = '0;
        end
        for (int k = 0; k < n; k++) begin
            entry.data = made[k];
            entry.last = (k == n - 1);
            expected_bytes.push_back(entry);
        end
    endfunction

    always @(posedge i_clk) begin
        t_stream_byte want;
        if (!i_rst_n) begin
            partial_bits = '0;
            partial_cnt  = '0;
            expected_bytes.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected output byte 0x%02h last %0b", $time,
                             i_m_tdata, i_m_tlast);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_m_tdata !== want.data) begin
                        $display("%0t: byte expected 0x%02h actual 0x%02h", $time,
                                 want.data, i_m_tdata);
                        fail_count++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $display("%0t: tlast expected %0b actual %0b", $time,
                                 want.last, i_m_tlast);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                append_field(i_s_tdata[CNT_W-1:0], i_s_tdata[CNT_W+VALUE_W-1:CNT_W], i_s_tuser);
        end
        o_fail_count  <= fail_count;
        o_outstanding <= expected_bytes.size();
    end

endmodule

// File: tb/tb_top.sv
// Testbench top of the MSB-first bit packer: clock, reset, stimulus and the final verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mfbp_pkg::*;

    // Generous cycle budget for the whole run.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 100;
    // The final stretch of the random part runs with no idling on either side.
    localparam int CALM_TAIL    = 20;
    // Cycles allowed after the last expected byte, for anything stray.
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata  = '0;   // [5:0] bit_count, [37:6] bit_value, [39:38] zero
    logic        i_s_tuser  = 1'b0; // [0] pad_to_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;         // [7:0] out_byte
    logic        o_m_tlast;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    // Enables random idling on both channels; updated only at clock edges.
    logic gaps_on   = 1'b0;
    int   ready_hold = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    msb_first_bit_packer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    mfbp_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tlast     (o_m_tlast),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // The watchdog ends a hung run. It counts every cycle, reset included.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("msb_first_bit_packer test failed");
            $finish;
        end
    end

    // Output side back-pressure. A stall drops tready for a run of cycles whose length is drawn
    // into ready_hold, which counts the remaining low cycles. With gaps off, tready stays high.
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            i_m_tready <= (ready_hold == 1);
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            ready_hold <= $urandom_range(1, 4);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Offers one field on the input channel and returns at the edge where the transaction
    // completes. The caller either presents the next field at that same edge or drops
    // tvalid, so every input gets one nonblocking assignment per edge at most.
    task automatic send_field(logic [CNT_W-1:0] count, logic [VALUE_W-1:0] value, logic pad);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, value, count};
        i_s_tuser  <= pad;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Draws one random field. Most widths are legal (1 to 32); the rest cover the zero
    // width and widths above the limit, which saturate. Values lean toward random words
    // with some all-zero and all-one patterns so that masking is exercised at both ends.
    task automatic send_random_field();
        logic [CNT_W-1:0]   count;
        logic [VALUE_W-1:0] value;
        logic               pad;
        case ($urandom_range(0, 9))
            0:       count = '0;
            1:       count = CNT_W'($urandom_range(MAX_FIELD_BITS + 1, (1 << CNT_W) - 1));
            2, 3:    count = CNT_W'($urandom_range(1, 8));
            default: count = CNT_W'($urandom_range(1, MAX_FIELD_BITS));
        endcase
        case ($urandom_range(0, 7))
            0:       value = '0;
            1:       value = '1;
            default: value = $urandom();
        endcase
        pad = ($urandom_range(0, 3) == 0);
        send_field(count, value, pad);
    endtask

    initial begin
        // Synchronous reset, held low from the start and then released.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: byte-aligned fields, the widest field, partial bytes, the zero
        // width with and without a partial byte, a pad when aligned, widths above the
        // limit, values wider than their width, and a field that yields five bytes.
        gaps_on <= 1'b1;
        send_field(6'd8,  32'h0000_00A5, 1'b0);
        send_field(6'd1,  32'h0000_0001, 1'b0);
        send_field(6'd32, 32'hFFFF_FFFF, 1'b0);
        send_field(6'd0,  32'h0000_0000, 1'b1);
        send_field(6'd0,  32'hFFFF_FFFF, 1'b1);
        send_field(6'd32, 32'h0000_0000, 1'b0);
        send_field(6'd63, 32'hFFFF_FFFF, 1'b0);
        send_field(6'd33, 32'h8000_0001, 1'b1);
        send_field(6'd7,  32'h0000_007F, 1'b0);
        send_field(6'd32, 32'h1234_5678, 1'b1);
        send_field(6'd3,  32'hFFFF_FFF8, 1'b0);
        send_field(6'd5,  32'h0000_001F, 1'b0);
        send_field(6'd40, 32'hDEAD_BEEF, 1'b1);
        send_field(6'd16, 32'hFFFF_0000, 1'b1);
        send_field(6'd1,  32'h0000_0000, 1'b1);
        send_field(6'd48, 32'h0F0F_0F0F, 1'b0);
        send_field(6'd31, 32'h7FFF_FFFF, 1'b1);
        send_field(6'd0,  32'h5555_5555, 1'b0);
        send_field(6'd2,  32'hAAAA_AAAA, 1'b0);
        send_field(6'd32, 32'hAAAA_AAAA, 1'b1);

        // Random part. Idling switches on and off in stretches of twenty transactions and
        // is off for the final stretch.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 20 == 0)
                gaps_on <= (k < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            send_random_field();
        end
        i_s_tvalid <= 1'b0;
        gaps_on    <= 1'b0;

        // Wait for every predicted byte, then a little longer for anything stray.
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (outstanding != 0)
            $display("%0t: %0d expected bytes never arrived", $time, outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("msb_first_bit_packer test passed");
        end else begin
            $display("msb_first_bit_packer test failed");
        end
        $finish;
    end

endmodule
